// File: rtl/peq_pkg.sv
// Shared types, constants and helpers for the pointer event queue.
// Used by peq_cell and pointer_event_queue_move_eviction; no dependencies.
package peq_pkg;

	localparam int DEPTH   = 16;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int COORD_W = 16;
	localparam int STAMP_W = 64;
	localparam int CAP_W   = 5;
	localparam int IDX_W   = 3;

	localparam logic [IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [IDX_W-1:0] REG_EXTENT_W = 3'd2;
	localparam logic [IDX_W-1:0] REG_EXTENT_H = 3'd3;
	localparam logic [IDX_W-1:0] REG_CAPACITY = 3'd4;

	localparam logic OP_REPORT = 1'b0;
	localparam logic OP_POLL   = 1'b1;

	localparam logic KIND_MOVE  = 1'b0;
	localparam logic KIND_CLICK = 1'b1;

	localparam logic [1:0] BTN_LEFT   = 2'd0;
	localparam logic [1:0] BTN_RIGHT  = 2'd1;
	localparam logic [1:0] BTN_MIDDLE = 2'd2;

	typedef struct packed {
		logic               kind;
		logic [1:0]         button;
		logic [COORD_W-1:0] rel_x;
		logic [COORD_W-1:0] rel_y;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic live;
		logic shift;
		logic load;
	} cell_ctrl_t;

	typedef enum logic {
		ST_IDLE,
		ST_PUSH
	} state_t;

	function automatic logic [COORD_W-1:0] clamp_rel(input logic [COORD_W-1:0] pos,
		input logic [COORD_W-1:0] origin, input logic [COORD_W-1:0] extent);
		logic signed [COORD_W:0] rel;
		logic [COORD_W-1:0]      res;
		rel = $signed({pos[COORD_W-1], pos}) - $signed({origin[COORD_W-1], origin});
		if (rel[COORD_W]) begin
			res = '0;
		end else if (rel[COORD_W-1:0] > extent) begin
			res = extent;
		end else begin
			res = rel[COORD_W-1:0];
		end
		return res;
	endfunction

endpackage

// File: rtl/peq_cell.sv
// One queue cell: holds a sample, loads a new sample on a load and takes its neighbor's sample on a shift.
// Depends on peq_pkg.
module peq_cell (
	input  logic              clk,
	input  peq_pkg::cell_ctrl_t ctrl,
	input  peq_pkg::entry_t   new_entry,
	input  peq_pkg::entry_t   next_entry,
	input  logic              seen_in,
	output logic              seen_out,
	output peq_pkg::entry_t   cur
);

	peq_pkg::entry_t entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			entry_q <= new_entry;
		end else if (ctrl.shift) begin
			entry_q <= next_entry;
		end
	end

	// The flag carries whether a live move sample sits at or below this cell.
	assign seen_out = seen_in | (ctrl.live & (entry_q.kind == peq_pkg::KIND_MOVE));
	assign cur      = entry_q;

endmodule

// File: rtl/pointer_event_queue_move_eviction.sv
// Pointer event queue with move-first eviction, built as a row of shifting cells.
// A poll's result is registered and appears in the cycle after the request is accepted.
// A report queues 0 to 4 samples in the push state, since the single cell row
// takes one push with its eviction per cycle. One request is in flight at a time.
// Reset clears the fill count, the drop counter and the output valid flag, and loads the
// register defaults; queue cells hold no reset value.
module pointer_event_queue_move_eviction (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [peq_pkg::IDX_W-1:0]     cfg_index,
	input  logic [peq_pkg::COORD_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          op,
	input  logic signed [15:0]            pos_x,
	input  logic signed [15:0]            pos_y,
	input  logic signed [15:0]            delta_x,
	input  logic signed [15:0]            delta_y,
	input  logic                          left_down,
	input  logic                          right_down,
	input  logic                          middle_down,
	input  logic [63:0]                   stamp,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          sample_valid,
	output logic                          sample_kind,
	output logic [1:0]                    button_id,
	output logic [15:0]                   rel_x,
	output logic [15:0]                   rel_y,
	output logic [63:0]                   sample_stamp,
	output logic [63:0]                   drop_total
);

	localparam int DEPTH = peq_pkg::DEPTH;
	localparam int CNT_W = peq_pkg::CNT_W;

	logic [15:0]                origin_x_q;
	logic [15:0]                origin_y_q;
	logic [15:0]                extent_w_q;
	logic [15:0]                extent_h_q;
	logic [peq_pkg::CAP_W-1:0]  capacity_q;

	peq_pkg::state_t            state_q;
	peq_pkg::state_t            state_d;
	logic [CNT_W-1:0]           fill_q;
	logic [63:0]                drop_q;
	logic [3:0]                 mask_q;
	logic [15:0]                rx_q;
	logic [15:0]                ry_q;
	logic [63:0]                stamp_q;

	logic                       out_valid_q;
	logic                       smp_valid_q;
	logic                       smp_kind_q;
	logic [1:0]                 smp_button_q;
	logic [15:0]                smp_rx_q;
	logic [15:0]                smp_ry_q;
	logic [63:0]                smp_stamp_q;
	logic [63:0]                drop_out_q;

	logic                       in_acc;
	logic                       poll_acc;
	logic                       report_acc;
	logic [3:0]                 mask_in;
	logic                       push_now;
	logic                       push_last;
	logic [3:0]                 mask_rest;
	logic                       pop_now;
	logic [CNT_W-1:0]           eff_cap;
	logic                       evict;
	logic [CNT_W-1:0]           fill_after;
	logic [63:0]                drop_next;
	logic                       any_move;
	peq_pkg::entry_t            new_entry;
	logic                       emit_poll;
	logic                       emit_zero;

	peq_pkg::entry_t            cells   [DEPTH];
	peq_pkg::cell_ctrl_t        ctrl    [DEPTH];
	logic [DEPTH:0]             seen;

	assign in_ready   = (state_q == peq_pkg::ST_IDLE) & (~out_valid_q | out_ready);
	assign in_acc     = in_valid & in_ready;
	assign poll_acc   = in_acc & (op == peq_pkg::OP_POLL);
	assign report_acc = in_acc & (op == peq_pkg::OP_REPORT);
	assign mask_in    = {middle_down, right_down, left_down, (delta_x != '0) | (delta_y != '0)};

	assign push_now   = (state_q == peq_pkg::ST_PUSH);
	assign mask_rest  = mask_q & (mask_q - 4'd1);
	assign push_last  = push_now & (mask_rest == '0);
	assign pop_now    = poll_acc & (fill_q != '0);

	always_comb begin
		if (capacity_q == '0) begin
			eff_cap = CNT_W'(1);
		end else if (int'(capacity_q) > DEPTH) begin
			eff_cap = CNT_W'(DEPTH);
		end else begin
			eff_cap = CNT_W'(capacity_q);
		end
	end

	assign evict      = push_now & (fill_q >= eff_cap) & (fill_q != '0);
	assign fill_after = fill_q - CNT_W'(evict);
	assign drop_next  = drop_q + 64'(evict);

	always_comb begin
		new_entry.kind   = mask_q[0] ? peq_pkg::KIND_MOVE : peq_pkg::KIND_CLICK;
		new_entry.rel_x  = rx_q;
		new_entry.rel_y  = ry_q;
		new_entry.stamp  = stamp_q;
		if (mask_q[0] || mask_q[1]) begin
			new_entry.button = peq_pkg::BTN_LEFT;
		end else if (mask_q[2]) begin
			new_entry.button = peq_pkg::BTN_RIGHT;
		end else begin
			new_entry.button = peq_pkg::BTN_MIDDLE;
		end
	end

	assign seen[0]  = 1'b0;
	assign any_move = seen[DEPTH];

	// A click evicts from the oldest move upward; with no move queued, or for a
	// move, every cell shifts so the oldest entry falls out.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign ctrl[i].live  = (CNT_W'(i) < fill_q);
		assign ctrl[i].shift = pop_now | (evict & ((new_entry.kind == peq_pkg::KIND_MOVE) |
			~any_move | seen[i+1]));
		assign ctrl[i].load  = push_now & (fill_after == CNT_W'(i));

		peq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl[i]),
			.new_entry  (new_entry),
			.next_entry ((i == DEPTH - 1) ? cells[i] : cells[(i + 1) % DEPTH]),
			.seen_in    (seen[i]),
			.seen_out   (seen[i+1]),
			.cur        (cells[i])
		);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			peq_pkg::ST_IDLE: begin
				if (report_acc && (mask_in != '0)) begin
					state_d = peq_pkg::ST_PUSH;
				end
			end
			peq_pkg::ST_PUSH: begin
				if (push_last) begin
					state_d = peq_pkg::ST_IDLE;
				end
			end
			default: state_d = peq_pkg::ST_IDLE;
		endcase
	end

	assign emit_poll = pop_now;
	assign emit_zero = (poll_acc & (fill_q == '0)) | (report_acc & (mask_in == '0)) | push_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= peq_pkg::ST_IDLE;
			fill_q      <= '0;
			drop_q      <= '0;
			mask_q      <= '0;
			out_valid_q <= 1'b0;
			origin_x_q  <= 16'd0;
			origin_y_q  <= 16'd0;
			extent_w_q  <= 16'd1920;
			extent_h_q  <= 16'd1080;
			capacity_q  <= 5'd16;
		end else begin
			state_q <= state_d;
			drop_q  <= drop_next;
			if (pop_now) begin
				fill_q <= fill_q - CNT_W'(1);
			end else if (push_now) begin
				fill_q <= fill_after + CNT_W'(1);
			end
			if (report_acc) begin
				mask_q <= mask_in;
			end else if (push_now) begin
				mask_q <= mask_rest;
			end
			if (emit_poll || emit_zero) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_write) begin
				case (cfg_index)
					peq_pkg::REG_ORIGIN_X: origin_x_q <= cfg_data;
					peq_pkg::REG_ORIGIN_Y: origin_y_q <= cfg_data;
					peq_pkg::REG_EXTENT_W: extent_w_q <= cfg_data;
					peq_pkg::REG_EXTENT_H: extent_h_q <= cfg_data;
					peq_pkg::REG_CAPACITY: capacity_q <= cfg_data[peq_pkg::CAP_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (report_acc) begin
			rx_q    <= peq_pkg::clamp_rel(pos_x, origin_x_q, extent_w_q);
			ry_q    <= peq_pkg::clamp_rel(pos_y, origin_y_q, extent_h_q);
			stamp_q <= stamp;
		end
		if (emit_poll) begin
			smp_valid_q  <= 1'b1;
			smp_kind_q   <= cells[0].kind;
			smp_button_q <= cells[0].button;
			smp_rx_q     <= cells[0].rel_x;
			smp_ry_q     <= cells[0].rel_y;
			smp_stamp_q  <= cells[0].stamp;
			drop_out_q   <= drop_q;
		end else if (emit_zero) begin
			smp_valid_q  <= 1'b0;
			smp_kind_q   <= 1'b0;
			smp_button_q <= '0;
			smp_rx_q     <= '0;
			smp_ry_q     <= '0;
			smp_stamp_q  <= '0;
			drop_out_q   <= drop_next;
		end
	end

	assign out_valid    = out_valid_q;
	assign sample_valid = smp_valid_q;
	assign sample_kind  = smp_kind_q;
	assign button_id    = smp_button_q;
	assign rel_x        = smp_rx_q;
	assign rel_y        = smp_ry_q;
	assign sample_stamp = smp_stamp_q;
	assign drop_total   = drop_out_q;

endmodule

// File: sim/peq_tb_pkg.sv
// Request and output types plus the scoreboard class for the pointer event queue bench.
// The scoreboard keeps its own copy of the queue, the drop counter and the registers.
// Depends on peq_pkg from the RTL.
package peq_tb_pkg;
	import peq_pkg::*;

	typedef struct {
		logic               op;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] delta_x;
		logic signed [15:0] delta_y;
		logic               left_down;
		logic               right_down;
		logic               middle_down;
		logic [63:0]        stamp;
	} pointer_request_t;

	typedef struct {
		logic        sample_valid;
		logic        sample_kind;
		logic [1:0]  button_id;
		logic [15:0] rel_x;
		logic [15:0] rel_y;
		logic [63:0] sample_stamp;
		logic [63:0] drop_total;
	} queue_output_t;

	class peq_scoreboard;
		logic signed [15:0] origin_x;
		logic signed [15:0] origin_y;
		logic [15:0]        extent_w;
		logic [15:0]        extent_h;
		logic [CAP_W-1:0]   capacity;
		entry_t             queued_samples[$];
		logic [63:0]        drop_count;
		queue_output_t      pending_outputs[$];
		int                 mismatches;
		int                 request_total;
		int                 sample_total;
		int                 output_total;

		function new();
			origin_x = '0;
			origin_y = '0;
			extent_w = 16'd1920;
			extent_h = 16'd1080;
			capacity = 5'd16;
			drop_count = '0;
			mismatches = 0;
			request_total = 0;
			sample_total = 0;
			output_total = 0;
		endfunction

		function void set_register(logic [IDX_W-1:0] index, logic [15:0] value);
			case (index)
			REG_ORIGIN_X: origin_x = value;
			REG_ORIGIN_Y: origin_y = value;
			REG_EXTENT_W: extent_w = value;
			REG_EXTENT_H: extent_h = value;
			REG_CAPACITY: capacity = value[CAP_W-1:0];
			default: ;
			endcase
		endfunction

		function logic [15:0] clamp_axis(logic signed [15:0] pos, logic signed [15:0] origin,
			logic [15:0] extent);
			int rel;
			rel = int'(pos) - int'(origin);
			if (rel < 0) begin
				return '0;
			end
			if (rel > int'(extent)) begin
				return extent;
			end
			return rel[15:0];
		endfunction

		function void queue_sample(logic kind, logic [1:0] button, logic [15:0] rx,
			logic [15:0] ry, logic [63:0] stamp);
			int     limit;
			int     victim;
			entry_t fresh;
			limit = (capacity == 0) ? 1 : (capacity > DEPTH) ? DEPTH : int'(capacity);
			if (queued_samples.size() >= limit && queued_samples.size() > 0) begin
				victim = 0;
				if (kind == KIND_CLICK) begin
					for (int i = queued_samples.size() - 1; i >= 0; i--) begin
						if (queued_samples[i].kind == KIND_MOVE) begin
							victim = i;
						end
					end
				end
				queued_samples.delete(victim);
				drop_count++;
			end
			if (queued_samples.size() < DEPTH) begin
				fresh.kind = kind;
				fresh.button = button;
				fresh.rel_x = rx;
				fresh.rel_y = ry;
				fresh.stamp = stamp;
				queued_samples.insert(queued_samples.size(), fresh);
			end
		endfunction

		function void note_request(pointer_request_t req);
			queue_output_t result;
			logic [15:0]   rx;
			logic [15:0]   ry;
			entry_t        head;
			result = '{default: '0};
			request_total++;
			if (req.op == OP_REPORT) begin
				rx = clamp_axis(req.pos_x, origin_x, extent_w);
				ry = clamp_axis(req.pos_y, origin_y, extent_h);
				if (req.delta_x != 0 || req.delta_y != 0) begin
					queue_sample(KIND_MOVE, '0, rx, ry, req.stamp);
				end
				if (req.left_down) begin
					queue_sample(KIND_CLICK, BTN_LEFT, rx, ry, req.stamp);
				end
				if (req.right_down) begin
					queue_sample(KIND_CLICK, BTN_RIGHT, rx, ry, req.stamp);
				end
				if (req.middle_down) begin
					queue_sample(KIND_CLICK, BTN_MIDDLE, rx, ry, req.stamp);
				end
			end else if (queued_samples.size() > 0) begin
				head = queued_samples[0];
				queued_samples.delete(0);
				result.sample_valid = 1'b1;
				result.sample_kind = head.kind;
				result.button_id = head.button;
				result.rel_x = head.rel_x;
				result.rel_y = head.rel_y;
				result.sample_stamp = head.stamp;
			end
			result.drop_total = drop_count;
			pending_outputs.insert(pending_outputs.size(), result);
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("Output %0d: %s expected %h, got %h", output_total, name, want, got);
				end
			end
		endfunction

		function void check_result(queue_output_t got);
			queue_output_t want;
			output_total++;
			if (pending_outputs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("Output %0d arrived with no request outstanding.", output_total);
				end
				return;
			end
			want = pending_outputs[0];
			pending_outputs.delete(0);
			if (want.sample_valid) begin
				sample_total++;
			end
			compare_field("sample_valid", want.sample_valid, got.sample_valid);
			compare_field("sample_kind", want.sample_kind, got.sample_kind);
			compare_field("button_id", want.button_id, got.button_id);
			compare_field("rel_x", want.rel_x, got.rel_x);
			compare_field("rel_y", want.rel_y, got.rel_y);
			compare_field("sample_stamp", want.sample_stamp, got.sample_stamp);
			compare_field("drop_total", want.drop_total, got.drop_total);
		endfunction
	endclass

endpackage

// File: sim/tb_pointer_event_queue_move_eviction.sv
// Top-level bench for pointer_event_queue_move_eviction: directed and random requests
// under random register settings and random stalls on both sides.
// Depends on peq_pkg, peq_tb_pkg and the RTL top.
module tb_pointer_event_queue_move_eviction;
	timeunit 1ns;
	timeprecision 1ps;

	import peq_pkg::*;
	import peq_tb_pkg::*;

	localparam int IDLE_LIMIT   = 4000;
	localparam int RANDOM_ITEMS = 1800;
	localparam int DRAIN_CYCLES = 8;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write;
	logic [IDX_W-1:0]     cfg_index;
	logic [COORD_W-1:0]   cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic                 op;
	logic signed [15:0]   pos_x;
	logic signed [15:0]   pos_y;
	logic signed [15:0]   delta_x;
	logic signed [15:0]   delta_y;
	logic                 left_down;
	logic                 right_down;
	logic                 middle_down;
	logic [63:0]          stamp;
	logic                 out_valid;
	logic                 out_ready;
	logic                 sample_valid;
	logic                 sample_kind;
	logic [1:0]           button_id;
	logic [15:0]          rel_x;
	logic [15:0]          rel_y;
	logic [63:0]          sample_stamp;
	logic [63:0]          drop_total;

	peq_scoreboard        sample_board;
	int                   idle_cycles;
	int                   setting_count;
	int                   send_burst;
	int                   take_burst;
	logic signed [15:0]   cur_origin_x;
	logic signed [15:0]   cur_origin_y;
	logic [15:0]          cur_extent_w;
	logic [15:0]          cur_extent_h;

	pointer_event_queue_move_eviction i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_write) begin
				sample_board.set_register(cfg_index, cfg_data);
			end
			if (in_valid && in_ready) begin
				sample_board.note_request('{op, pos_x, pos_y, delta_x, delta_y,
					left_down, right_down, middle_down, stamp});
			end
			if (out_valid && out_ready) begin
				sample_board.check_result('{sample_valid, sample_kind, button_id,
					rel_x, rel_y, sample_stamp, drop_total});
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) @(posedge clk);
		$display("tb_pointer_event_queue_move_eviction: errors");
		$finish;
	end

	function automatic int draw_wait(inout int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0) begin
			burst = $urandom_range(10, 50);
			return 0;
		end
		return $urandom_range(0, 14);
	endfunction

	initial begin
		int gap;
		take_burst = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = draw_wait(take_burst);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_request(pointer_request_t req);
		int gap;
		gap = draw_wait(send_burst);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		op <= req.op;
		pos_x <= req.pos_x;
		pos_y <= req.pos_y;
		delta_x <= req.delta_x;
		delta_y <= req.delta_y;
		left_down <= req.left_down;
		right_down <= req.right_down;
		middle_down <= req.middle_down;
		stamp <= req.stamp;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_report(logic [15:0] px, logic [15:0] py, logic [15:0] dx,
		logic [15:0] dy, logic l, logic r, logic m, logic [63:0] st);
		pointer_request_t req;
		req = '{OP_REPORT, px, py, dx, dy, l, r, m, st};
		send_request(req);
	endtask

	task automatic send_poll();
		pointer_request_t req;
		req = '{OP_POLL, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			1'($urandom), 1'($urandom), 1'($urandom), {$urandom, $urandom}};
		send_request(req);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sample_board.pending_outputs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_settings(logic [15:0] ox, logic [15:0] oy, logic [15:0] ew,
		logic [15:0] eh, logic [15:0] cap);
		logic [IDX_W-1:0] regs[5] = '{REG_ORIGIN_X, REG_ORIGIN_Y, REG_EXTENT_W,
			REG_EXTENT_H, REG_CAPACITY};
		logic [15:0]      vals[5];
		vals = '{ox, oy, ew, eh, cap};
		for (int i = 0; i < 5; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_write <= 1'b0;
		cur_origin_x = ox;
		cur_origin_y = oy;
		cur_extent_w = ew;
		cur_extent_h = eh;
		setting_count++;
	endtask

	function automatic logic [15:0] pick_origin();
		case ($urandom_range(0, 4))
		0: return 16'h8000;
		1: return 16'h7fff;
		2: return 16'h0000;
		default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_extent();
		case ($urandom_range(0, 5))
		0: return 16'h0000;
		1: return 16'h0001;
		2: return 16'hffff;
		default: return 16'($urandom_range(1, 4000));
		endcase
	endfunction

	task automatic random_settings();
		logic [15:0] cap;
		case ($urandom_range(0, 7))
		0: cap = 16'd0;
		1: cap = 16'd31;
		2: cap = 16'd17;
		3: cap = 16'd16;
		4: cap = 16'd1;
		default: cap = 16'($urandom_range(1, 16));
		endcase
		if ($urandom_range(0, 3) == 0) begin
			cap = cap | (16'($urandom) & 16'hffe0);
		end
		program_settings(pick_origin(), pick_origin(), pick_extent(), pick_extent(), cap);
	endtask

	function automatic logic [15:0] pick_position(logic [15:0] origin, logic [15:0] extent);
		case ($urandom_range(0, 3))
		0: return 16'($urandom);
		1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
		default: return origin + 16'($urandom_range(0, int'(extent) + 16)) - 16'd8;
		endcase
	endfunction

	function automatic pointer_request_t random_report();
		pointer_request_t req;
		req.op = OP_REPORT;
		req.pos_x = pick_position(cur_origin_x, cur_extent_w);
		req.pos_y = pick_position(cur_origin_y, cur_extent_h);
		case ($urandom_range(0, 3))
		0: begin
			req.delta_x = '0;
			req.delta_y = '0;
		end
		1: begin
			req.delta_x = 16'($urandom);
			req.delta_y = '0;
		end
		2: begin
			req.delta_x = '0;
			req.delta_y = 16'($urandom);
		end
		default: begin
			req.delta_x = 16'($urandom);
			req.delta_y = 16'($urandom);
		end
		endcase
		req.left_down = 1'($urandom);
		req.right_down = 1'($urandom);
		req.middle_down = 1'($urandom);
		req.stamp = {$urandom, $urandom};
		return req;
	endfunction

	initial begin
		int random_sent;
		int phase_len;
		int poll_pct;
		sample_board = new();
		setting_count = 0;
		send_burst = 0;
		random_sent = 0;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		op = OP_REPORT;
		pos_x = '0;
		pos_y = '0;
		delta_x = '0;
		delta_y = '0;
		left_down = 1'b0;
		right_down = 1'b0;
		middle_down = 1'b0;
		stamp = '0;
		out_ready = 1'b0;
		cur_origin_x = '0;
		cur_origin_y = '0;
		cur_extent_w = 16'd1920;
		cur_extent_h = 16'd1080;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default registers: empty poll, a report that queues nothing, clamping at both ends.
		send_poll();
		send_report(16'd100, 16'd200, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 64'h1);
		send_report(16'h7fff, 16'h8000, 16'h0001, 16'h0000, 1'b0, 1'b0, 1'b0, '1);
		send_report(16'hffff, 16'd500, 16'h0000, 16'h8000, 1'b1, 1'b0, 1'b0, '0);
		send_report(16'd1920, 16'd1080, 16'h0000, 16'h0000, 1'b0, 1'b1, 1'b1,
			64'h8000_0000_0000_0000);
		repeat (5) send_poll();
		settle();

		// Capacity two with a zero height: clicks evict the queued move first.
		program_settings(16'h8000, 16'h7fff, 16'hffff, 16'h0000, 16'd2);
		send_report(16'h7fff, 16'h7fff, 16'hffff, 16'hffff, 1'b1, 1'b1, 1'b1,
			64'h0123_4567_89ab_cdef);
		send_report(16'h8000, 16'h0000, 16'h7fff, 16'h0000, 1'b0, 1'b0, 1'b0,
			64'hfedc_ba98_7654_3210);
		repeat (3) send_poll();
		settle();

		// Capacity zero behaves as one.
		program_settings(16'h7fff, 16'h8000, 16'd1, 16'd1, 16'd0);
		send_report(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0, 64'h10);
		send_report(16'h7fff, 16'h8000, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1, 64'h11);
		send_report(16'h8000, 16'h7fff, 16'h8000, 16'h0000, 1'b0, 1'b0, 1'b0, 64'h12);
		repeat (2) send_poll();
		settle();

		// Fill six entries, then lower the capacity below the fill level.
		program_settings(16'h0000, 16'h0000, 16'd640, 16'd480, 16'd16);
		send_report(16'd10, 16'd10, 16'h0001, 16'h0001, 1'b1, 1'b1, 1'b1, 64'h20);
		send_report(16'd20, 16'd20, 16'h0000, 16'h0005, 1'b1, 1'b0, 1'b0, 64'h21);
		settle();
		program_settings(16'h0000, 16'h0000, 16'd640, 16'd480, 16'd3);
		send_report(16'd30, 16'd30, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0, 64'h22);
		send_report(16'd40, 16'd40, 16'h0003, 16'h0000, 1'b0, 1'b0, 1'b0, 64'h23);
		repeat (2) send_poll();

		while (random_sent < RANDOM_ITEMS) begin
			settle();
			random_settings();
			phase_len = $urandom_range(60, 200);
			if (phase_len > RANDOM_ITEMS - random_sent) begin
				phase_len = RANDOM_ITEMS - random_sent;
			end
			poll_pct = $urandom_range(10, 85);
			repeat (phase_len) begin
				if ($urandom_range(1, 100) <= poll_pct) begin
					send_poll();
				end else begin
					send_request(random_report());
				end
				random_sent++;
			end
		end
		settle();

		$display("Run covered %0d requests, %0d returned samples and %0d evictions over %0d settings.",
			sample_board.request_total, sample_board.sample_total,
			sample_board.drop_count, setting_count);
		if (sample_board.mismatches == 0 && sample_board.pending_outputs.size() == 0) begin
			$display("tb_pointer_event_queue_move_eviction: clean");
		end else begin
			$display("tb_pointer_event_queue_move_eviction: errors");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/peq_pkg.sv
rtl/peq_cell.sv
rtl/pointer_event_queue_move_eviction.sv
sim/peq_tb_pkg.sv
sim/tb_pointer_event_queue_move_eviction.sv
